// ----- rtl/cle_pkg.sv -----
// Shared types and constants for the circular list engine.
`default_nettype none

package cle_pkg;

  // Default node pool size and the longest dump in result items
  localparam int unsigned CapacityDef = 32;
  localparam int unsigned MaxResults  = 32;

  typedef enum logic [2:0] {
    ACT_INSERT_FIRST = 3'd0,
    ACT_INSERT_AFTER = 3'd1,
    ACT_DELETE       = 3'd2,
    ACT_FIND         = 3'd3,
    ACT_DUMP         = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MISS      = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_EMPTY = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  // Requests from the sequencer to the slot pool
  typedef struct packed {
    logic scan;   // start a lowest-free search from slot zero
    logic set;    // mark idx as used
    logic clr;    // mark idx as free
  } pool_req_t;

endpackage

`default_nettype wire

// ----- rtl/cle_slot_pool.sv -----
// Slot-used flags and a one-slot-per-cycle search for the lowest free slot.
`default_nettype none

module cle_slot_pool #(
  parameter int unsigned CAPACITY = cle_pkg::CapacityDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  cle_pkg::pool_req_t           req_i,
  input  wire [$clog2(CAPACITY)-1:0]   idx_i,
  output logic [$clog2(CAPACITY)-1:0]  free_idx_o,
  output logic                         done_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic [CAPACITY-1:0] used_q;
  logic [AW-1:0]       scan_q;
  logic                scanning_q;
  logic                done_q;

  // Track which slots hold ring nodes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      if (req_i.set) used_q[idx_i] <= 1'b1;
      if (req_i.clr) used_q[idx_i] <= 1'b0;
    end
  end

  // Step through the slots until a free one turns up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= '0;
      scanning_q <= 1'b0;
      done_q     <= 1'b0;
    end else if (req_i.scan) begin
      scan_q     <= '0;
      scanning_q <= 1'b1;
      done_q     <= 1'b0;
    end else if (scanning_q) begin
      if (!used_q[scan_q]) begin
        scanning_q <= 1'b0;
        done_q     <= 1'b1;
      end else begin
        scan_q <= scan_q + AW'(1);
      end
    end
  end

  assign free_idx_o = scan_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

// ----- rtl/circular_list_engine.sv -----
// Insert first takes slot zero, since an empty ring leaves every slot free; find, insert
// after and delete walk one node per cycle, at most once around the ring; a dump gives one
// item per cycle while the output is not stalled.
// Throughput: one command at a time; the walk through the node memory read port sets it.
// The free-slot search runs one slot per cycle beside the walk.
// Reset: the ring is empty, the cursor is zero and no slot is used; node memories
// are not cleared.
`default_nettype none

module circular_list_engine #(
  parameter int unsigned CAPACITY = cle_pkg::CapacityDef
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [2:0]         action_i,
  input  wire  signed [31:0] new_value_i,
  input  wire  signed [31:0] key_value_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] item_value_o,
  output logic               last_o,
  output logic [5:0]         node_count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GRAB,
    S_SEEK,
    S_INS_WAIT,
    S_INS_LINK,
    S_DPRIME,
    S_DEL,
    S_DUMP,
    S_RESP
  } state_e;

  // Node memories
  logic signed [31:0] node_value [CAPACITY];
  logic [AW-1:0]      node_link  [CAPACITY];

  logic               val_we;
  logic [AW-1:0]      val_waddr;
  logic signed [31:0] val_wdata;
  logic               link_we;
  logic [AW-1:0]      link_waddr;
  logic [AW-1:0]      link_wdata;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_val_q;
  logic [AW-1:0]      rd_link_q;
  logic [AW-1:0]      rd_addr_q;

  // Sequencer state
  state_e             state_q;
  cle_pkg::action_e   act_q;
  logic signed [31:0] nv_q;
  logic signed [31:0] key_q;
  cle_pkg::status_e   resp_st_q;
  logic [AW-1:0]      cursor_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      step_q;
  logic [AW-1:0]      prev_q;
  logic [AW-1:0]      link_sv_q;
  logic [AW-1:0]      slot_q;

  // Output register
  logic               out_valid_q;
  cle_pkg::status_e   status_q;
  logic signed [31:0] item_q;
  logic               last_q;
  logic [5:0]         ncount_q;

  // Pool interface
  cle_pkg::pool_req_t pool_req;
  logic [AW-1:0]      pool_idx;
  logic [AW-1:0]      free_idx;
  logic               free_done;

  logic               accept;
  logic               out_free;
  logic               emit;
  logic               hit;
  logic               walk_end;
  logic               dump_last;

  cle_slot_pool #(
    .CAPACITY (CAPACITY)
  ) u_pool (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (pool_req),
    .idx_i      (pool_idx),
    .free_idx_o (free_idx),
    .done_o     (free_done)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = out_free && ((state_q == S_DUMP) || (state_q == S_RESP));
  assign hit        = (rd_val_q == key_q);
  assign walk_end   = ((step_q + CW'(1)) == count_q);
  assign dump_last  = walk_end || (32'(step_q) == cle_pkg::MaxResults - 1);

  // Select the read address: prime at the cursor, then follow links
  always_comb begin
    case (state_q)
      S_SEEK, S_DPRIME, S_DEL: rd_addr = rd_link_q;
      S_DUMP:                  rd_addr = out_free ? rd_link_q : rd_addr_q;
      default:                 rd_addr = cursor_q;
    endcase
  end

  // Write ports and pool requests
  always_comb begin
    val_we     = 1'b0;
    val_waddr  = free_idx;
    val_wdata  = nv_q;
    link_we    = 1'b0;
    link_waddr = free_idx;
    link_wdata = free_idx;
    pool_req   = '0;
    pool_idx   = free_idx;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cle_pkg::action_e'(action_i) == cle_pkg::ACT_INSERT_FIRST) begin
            pool_req.scan = (count_q == '0);
          end else if (cle_pkg::action_e'(action_i) == cle_pkg::ACT_INSERT_AFTER) begin
            pool_req.scan = (count_q != '0) && (count_q != CW'(CAPACITY));
          end
        end
      end
      S_GRAB: begin
        if (free_done) begin
          val_we       = 1'b1;
          link_we      = 1'b1;
          pool_req.set = 1'b1;
        end
      end
      S_INS_WAIT: begin
        if (free_done) begin
          val_we       = 1'b1;
          link_we      = 1'b1;
          link_wdata   = link_sv_q;
          pool_req.set = 1'b1;
        end
      end
      S_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = cursor_q;
        link_wdata = slot_q;
      end
      S_DEL: begin
        if (hit) begin
          link_we      = 1'b1;
          link_waddr   = prev_q;
          link_wdata   = rd_link_q;
          pool_req.clr = 1'b1;
          pool_idx     = rd_addr_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Node memories: one write and one registered read each per cycle
  always_ff @(posedge clk_i) begin
    if (val_we) node_value[val_waddr] <= val_wdata;
    if (link_we) node_link[link_waddr] <= link_wdata;
    rd_val_q  <= node_value[rd_addr];
    rd_link_q <= node_link[rd_addr];
    rd_addr_q <= rd_addr;
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= cle_pkg::ACT_INSERT_FIRST;
      nv_q        <= '0;
      key_q       <= '0;
      resp_st_q   <= cle_pkg::ST_OK;
      cursor_q    <= '0;
      count_q     <= '0;
      step_q      <= '0;
      prev_q      <= '0;
      link_sv_q   <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= cle_pkg::ST_OK;
      item_q      <= '0;
      last_q      <= 1'b0;
      ncount_q    <= '0;
    end else begin
      // Drop the result once it is taken and nothing replaces it
      if (out_valid_q && !out_stall_i && !emit) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            act_q  <= cle_pkg::action_e'(action_i);
            nv_q   <= new_value_i;
            key_q  <= key_value_i;
            step_q <= '0;
            case (cle_pkg::action_e'(action_i))
              cle_pkg::ACT_INSERT_FIRST: begin
                if (count_q != '0) begin
                  resp_st_q <= cle_pkg::ST_NOT_EMPTY;
                  state_q   <= S_RESP;
                end else begin
                  resp_st_q <= cle_pkg::ST_OK;
                  state_q   <= S_GRAB;
                end
              end
              cle_pkg::ACT_INSERT_AFTER: begin
                if (count_q == '0) begin
                  resp_st_q <= cle_pkg::ST_EMPTY;
                  state_q   <= S_RESP;
                end else if (count_q == CW'(CAPACITY)) begin
                  resp_st_q <= cle_pkg::ST_FULL;
                  state_q   <= S_RESP;
                end else begin
                  resp_st_q <= cle_pkg::ST_OK;
                  state_q   <= S_SEEK;
                end
              end
              cle_pkg::ACT_DELETE: begin
                if (count_q == '0) begin
                  resp_st_q <= cle_pkg::ST_EMPTY;
                  state_q   <= S_RESP;
                end else begin
                  resp_st_q <= cle_pkg::ST_OK;
                  state_q   <= S_DPRIME;
                end
              end
              cle_pkg::ACT_FIND: begin
                if (count_q == '0) begin
                  resp_st_q <= cle_pkg::ST_EMPTY;
                  state_q   <= S_RESP;
                end else begin
                  resp_st_q <= cle_pkg::ST_OK;
                  state_q   <= S_SEEK;
                end
              end
              cle_pkg::ACT_DUMP: begin
                if (count_q == '0) begin
                  resp_st_q <= cle_pkg::ST_EMPTY;
                  state_q   <= S_RESP;
                end else begin
                  resp_st_q <= cle_pkg::ST_OK;
                  state_q   <= S_DUMP;
                end
              end
              default: begin
                resp_st_q <= cle_pkg::ST_OK;
                state_q   <= S_RESP;
              end
            endcase
          end
        end

        // Place the first node in the lowest free slot
        S_GRAB: begin
          if (free_done) begin
            cursor_q <= free_idx;
            count_q  <= CW'(1);
            state_q  <= S_RESP;
          end
        end

        // Walk from the cursor until the key matches or the ring is done
        S_SEEK: begin
          if (hit) begin
            cursor_q  <= rd_addr_q;
            link_sv_q <= rd_link_q;
            state_q   <= (act_q == cle_pkg::ACT_INSERT_AFTER) ? S_INS_WAIT : S_RESP;
          end else if (walk_end) begin
            resp_st_q <= cle_pkg::ST_MISS;
            state_q   <= S_RESP;
          end else begin
            step_q <= step_q + CW'(1);
          end
        end

        // Write the new node once a free slot is known
        S_INS_WAIT: begin
          if (free_done) begin
            slot_q  <= free_idx;
            state_q <= S_INS_LINK;
          end
        end

        // Link the match to the new node
        S_INS_LINK: begin
          count_q <= count_q + CW'(1);
          state_q <= S_RESP;
        end

        // Cursor data is in; the successor read is under way
        S_DPRIME: begin
          prev_q  <= rd_addr_q;
          state_q <= S_DEL;
        end

        // Check the successor of prev and unlink it on a match
        S_DEL: begin
          if (hit) begin
            count_q  <= count_q - CW'(1);
            cursor_q <= prev_q;
            state_q  <= S_RESP;
          end else if (walk_end) begin
            resp_st_q <= cle_pkg::ST_MISS;
            state_q   <= S_RESP;
          end else begin
            prev_q <= rd_addr_q;
            step_q <= step_q + CW'(1);
          end
        end

        // Emit one node per item, holding the read while stalled
        S_DUMP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= cle_pkg::ST_OK;
            item_q      <= rd_val_q;
            last_q      <= dump_last;
            ncount_q    <= 6'(count_q);
            step_q      <= step_q + CW'(1);
            if (dump_last) state_q <= S_IDLE;
          end
        end

        // Present the single result item
        S_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= resp_st_q;
            item_q      <= '0;
            last_q      <= 1'b1;
            ncount_q    <= 6'(count_q);
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign item_value_o = item_q;
  assign last_o       = last_q;
  assign node_count_o = ncount_q;

endmodule

`default_nettype wire
